// ===== design/rse_pkg.sv =====
// rse_pkg: shared types and constants for the randomized set engine
// holds the request and response transfer structs and the request codes
// no dependencies
`default_nettype none

package rse_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RAND_W = 31;
  localparam int unsigned TYPE_W = 2;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_PICK   = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]       req_type;
    logic signed [VAL_W-1:0] item_value;
    logic [RAND_W-1:0]       random_word;
  } req_t;

  typedef struct packed {
    logic                    success;
    logic signed [VAL_W-1:0] picked_value;
    logic                    set_full;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/randomized_set_engine.sv =====
// randomized_set_engine: set of distinct 32-bit values with insert, remove and pick
// top level sequencer, uses rse_pkg, rse_store and rse_mod_unit
//
// requests arrive on req/req_valid/req_stall, results leave on rsp/rsp_valid/rsp_stall;
// a transfer happens when valid is high and stall is low. every request gives
// exactly one response.
// insert and remove scan the member array one entry per cycle through the single
// read port. with the value absent the scan covers every member; a match ends
// the scan early, and remove then moves the last entry into the freed slot.
// pick runs a 31-step serial remainder (random_word mod member_count) and then
// one array read. pick on an empty set and unknown request types go straight
// to the response.
// one request is in flight at a time; req_stall is high while it is being
// worked on. a finished response sits in the output register, and the next
// request may be taken while it waits; if that request finishes before the
// response is taken, it holds until rsp_stall drops.
// reset empties the set (member count zero) and drops rsp_valid; the array
// contents need no clearing since only entries below the count are read.
`default_nettype none

module randomized_set_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rse_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rse_pkg::rsp_t rsp
);
  import rse_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_ACT     = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_MODWAIT = 3'd4;
  localparam logic [2:0] S_PICKRD  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_dec;
  logic [CW-1:0]    idx;
  logic             pend;
  logic [IW-1:0]    pidx;
  logic [IW-1:0]    slot;
  logic             found;
  req_t             cur;
  rsp_t             res;

  logic             accept;
  logic             hit;
  logic             has_room;
  logic             mod_start;
  logic             mod_done;
  logic [CW-1:0]    mod_rem;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [IW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign count_dec = count - 1'b1;
  assign has_room  = (count != CW'(CAPACITY));
  assign hit       = pend && (rd_data == $unsigned(cur.item_value));
  assign mod_start = accept && (req.req_type == REQ_PICK) && (count != '0);

  always_comb begin
    case (state)
      S_SEARCH:  rd_addr = idx[IW-1:0];
      S_ACT:     rd_addr = count_dec[IW-1:0];
      S_MODWAIT: rd_addr = mod_rem[IW-1:0];
      default:   rd_addr = idx[IW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = $unsigned(cur.item_value);
    case (state)
      S_ACT: begin
        wr_en = (cur.req_type == REQ_INSERT) && !found && has_room;
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  rse_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rse_mod_unit #(
    .DW (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.random_word),
    .divisor  (count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= 1'b0;
            case (req.req_type)
              REQ_INSERT, REQ_REMOVE: state <= S_SEARCH;
              REQ_PICK: begin
                if (count != '0) begin
                  state <= S_MODWAIT;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            pend  <= 1'b0;
            state <= S_ACT;
          end else if (idx >= count && !pend) begin
            state <= S_ACT;
          end else begin
            pend <= (idx < count);
          end
        end
        S_ACT: begin
          if (cur.req_type == REQ_REMOVE && found) begin
            state <= S_MOVE;
          end else begin
            if (wr_en) begin
              count <= count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_MOVE: begin
          count <= count_dec;
          state <= S_DONE;
        end
        S_MODWAIT: begin
          if (mod_done) begin
            state <= S_PICKRD;
          end
        end
        S_PICKRD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur   <= req;
          res   <= '0;
          idx   <= '0;
          found <= 1'b0;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found <= 1'b1;
          slot  <= pidx;
        end else if (idx < count) begin
          pidx <= idx[IW-1:0];
          idx  <= idx + 1'b1;
        end
      end
      S_ACT: begin
        if (cur.req_type == REQ_INSERT && !found) begin
          res.success  <= has_room;
          res.set_full <= !has_room;
        end
      end
      S_MOVE: begin
        res.success <= 1'b1;
      end
      S_PICKRD: begin
        res.picked_value <= $signed(rd_data);
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp <= res;
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("member count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))
    else $error("member count moved by more than one");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count))
    else $error("member count changed outside a request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.success && rsp.set_full))
    else $error("success and set_full both set");

  a_pick_only_value: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.success || rsp.set_full)) |-> (rsp.picked_value == '0))
    else $error("picked value set on an insert or remove");

endmodule

`default_nettype wire

// ===== design/rse_store.sv =====
// rse_store: member array of the randomized set engine
// one write port and one read port with registered read data, uses rse_pkg
`default_nettype none

module rse_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rse_pkg::VAL_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [rse_pkg::VAL_W-1:0] rd_data
);
  import rse_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/rse_mod_unit.sv =====
// rse_mod_unit: serial remainder unit, one dividend bit per cycle
// restoring scheme with a single shared subtract and compare, uses rse_pkg
`default_nettype none

module rse_mod_unit #(
  parameter int unsigned DW = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rse_pkg::RAND_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       done,
  output logic [DW-1:0]              rem
);
  import rse_pkg::*;

  localparam int unsigned NW = $clog2(RAND_W);

  logic              busy;
  logic [NW-1:0]     cnt;
  logic [RAND_W-1:0] quo;
  logic [DW-1:0]     dvs;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic [DW-1:0]     rem_next;

  always_comb begin
    trial = {rem, quo[RAND_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[DW-1:0];
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(RAND_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[RAND_W-2:0], 1'b0};
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for the randomized set engine
// drives insert, remove and pick requests with random gaps and response stalls,
// predicts each response from a mirror of the set; depends on rse_pkg and randomized_set_engine

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int POOL_SIZE = 96;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic signed [VAL_W-1:0] set_members [CAPACITY];
  int unsigned member_total = 0;
  rsp_t pending_responses [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit sender_bursty = 1'b1;
  int burst_left = 0;

  randomized_set_engine #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int find_member(input logic signed [VAL_W-1:0] v);
    for (int i = 0; i < member_total; i++)
      if (set_members[i] == v) return i;
    return -1;
  endfunction

  function automatic rsp_t next_set_response(input req_t r);
    rsp_t res;
    int slot;
    res = '0;
    slot = find_member(r.item_value);
    case (r.req_type)
      REQ_INSERT: begin
        if (slot < 0) begin
          if (member_total < CAPACITY) begin
            set_members[member_total] = r.item_value;
            member_total++;
            res.success = 1'b1;
          end else begin
            res.set_full = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (slot >= 0) begin
          set_members[slot] = set_members[member_total - 1];
          member_total--;
          res.success = 1'b1;
        end
      end
      REQ_PICK: begin
        if (member_total != 0)
          res.picked_value = set_members[{1'b0, r.random_word} % member_total];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [TYPE_W-1:0] kind,
                                    input logic [VAL_W-1:0] value,
                                    input logic [RAND_W-1:0] word);
    req_t r;
    r.req_type = kind;
    r.item_value = value;
    r.random_word = word;
    return r;
  endfunction

  // returns at the edge where the transfer happens, valid left high
  task automatic send_request(input req_t item);
    int gap;
    rsp_t predicted;
    if (sender_bursty && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    req <= item;
    req_valid <= 1'b1;
    do @(negedge clk); while (req_stall);
    @(posedge clk);
    predicted = next_set_response(item);
    pending_responses = {pending_responses, predicted};
  endtask

  task automatic test_basic_ops();
    sender_bursty = 1'b1;
    burst_left = 0;
    send_request(make_req(REQ_PICK, 32'd0, 31'h7fffffff));
    send_request(make_req(REQ_REMOVE, 32'd123, 31'd0));
    send_request(make_req(REQ_UNKNOWN, 32'hffffffff, 31'h7fffffff));
    send_request(make_req(REQ_INSERT, 32'h80000000, 31'd0));
    send_request(make_req(REQ_INSERT, 32'h7fffffff, 31'h7fffffff));
    send_request(make_req(REQ_INSERT, 32'd0, 31'd0));
    send_request(make_req(REQ_INSERT, 32'hffffffff, 31'd0));
    send_request(make_req(REQ_INSERT, 32'h80000000, 31'd0));
    send_request(make_req(REQ_PICK, 32'hffffffff, 31'd0));
    send_request(make_req(REQ_PICK, 32'd0, 31'h7fffffff));
    send_request(make_req(REQ_PICK, 32'd0, 31'd5));
    send_request(make_req(REQ_REMOVE, 32'h7fffffff, 31'd0));
    send_request(make_req(REQ_REMOVE, 32'd42, 31'd0));
    send_request(make_req(REQ_PICK, 32'd0, 31'd1));
    send_request(make_req(REQ_REMOVE, 32'hffffffff, 31'd0));
    send_request(make_req(REQ_REMOVE, 32'd0, 31'd0));
    send_request(make_req(REQ_REMOVE, 32'h80000000, 31'd0));
    send_request(make_req(REQ_PICK, 32'd0, 31'd0));
    send_request(make_req(REQ_UNKNOWN, 32'd0, 31'd0));
    send_request(make_req(REQ_INSERT, 32'h55555555, 31'h2aaaaaaa));
    send_request(make_req(REQ_INSERT, 32'haaaaaaaa, 31'h55555555));
    send_request(make_req(REQ_REMOVE, 32'haaaaaaaa, 31'd0));
    send_request(make_req(REQ_REMOVE, 32'h55555555, 31'd0));
  endtask

  task automatic test_full_set();
    logic signed [VAL_W-1:0] v;
    sender_bursty = 1'b0;
    while (member_total < CAPACITY)
      send_request(make_req(REQ_INSERT, $urandom, RAND_W'($urandom)));
    do v = $urandom; while (find_member(v) >= 0);
    send_request(make_req(REQ_INSERT, v, 31'd0));
    send_request(make_req(REQ_INSERT, set_members[CAPACITY - 1], 31'd0));
    send_request(make_req(REQ_REMOVE, v, 31'd0));
    send_request(make_req(REQ_PICK, 32'd0, 31'd0));
    send_request(make_req(REQ_PICK, 32'd0, 31'd63));
    send_request(make_req(REQ_PICK, 32'd0, 31'd64));
    send_request(make_req(REQ_PICK, 32'd0, 31'h7fffffff));
    send_request(make_req(REQ_REMOVE, set_members[0], 31'd0));
    send_request(make_req(REQ_INSERT, v, 31'd0));
    sender_bursty = 1'b1;
    burst_left = 0;
    while (member_total != 0) begin
      if ($urandom_range(0, 3) == 0)
        send_request(make_req(REQ_PICK, $urandom, RAND_W'($urandom)));
      send_request(make_req(REQ_REMOVE, set_members[$urandom_range(0, member_total - 1)],
                            RAND_W'($urandom)));
    end
  endtask

  // phases lean toward growing, shrinking or a balance, over a small value pool
  task automatic test_random_mix(input int total);
    req_t item;
    int sent;
    int phase_len;
    int roll;
    int ins_pct;
    int rem_pct;
    logic signed [VAL_W-1:0] value_pool [POOL_SIZE];
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(40, 240);
      case ($urandom_range(0, 2))
        0: begin
          ins_pct = 65;
          rem_pct = 15;
        end
        1: begin
          ins_pct = 20;
          rem_pct = 55;
        end
        default: begin
          ins_pct = 40;
          rem_pct = 35;
        end
      endcase
      sender_bursty = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      for (int k = 0; k < POOL_SIZE; k++)
        value_pool[k] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40)) - 20
                                                     : $urandom;
      for (int n = 0; n < phase_len && sent < total; n++) begin
        item.item_value = $urandom;
        item.random_word = RAND_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          item.req_type = REQ_UNKNOWN;
        end else if (roll < 2 + ins_pct) begin
          item.req_type = REQ_INSERT;
          if ($urandom_range(0, 4) != 0)
            item.item_value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (roll < 2 + ins_pct + rem_pct) begin
          item.req_type = REQ_REMOVE;
          if (member_total != 0 && $urandom_range(0, 9) < 6)
            item.item_value = set_members[$urandom_range(0, member_total - 1)];
          else if ($urandom_range(0, 1) == 1)
            item.item_value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          item.req_type = REQ_PICK;
          if ($urandom_range(0, 1) == 1)
            item.random_word = RAND_W'($urandom_range(0, 200));
        end
        send_request(item);
        sent++;
      end
    end
  endtask

  initial begin : rsp_stall_pattern
    int mode;
    int seg;
    forever begin
      mode = $urandom_range(0, 2);
      seg = $urandom_range(20, 200);
      repeat (seg) begin
        @(posedge clk);
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 9) < 3);
          default: rsp_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  always @(negedge clk) begin : check_responses
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_responses.size() == 0) begin
        $error("response transfer with nothing expected: %h", rsp);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (rsp.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, rsp.success);
          error_count++;
        end
        if (rsp.picked_value !== want.picked_value) begin
          $error("picked_value: expected %0d, got %0d", want.picked_value, rsp.picked_value);
          error_count++;
        end
        if (rsp.set_full !== want.set_full) begin
          $error("set_full: expected %0d, got %0d", want.set_full, rsp.set_full);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_full_set();
    test_random_mix(1370);
    req_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
